// ----- rtl/modular_inverse_defines.svh -----
// Assertion macros for the modular inverse block.
// Used by the port checker; needs nothing else.
`ifndef MODULAR_INVERSE_DEFINES_SVH
`define MODULAR_INVERSE_DEFINES_SVH

// Property checked while reset is released.
`define MI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/modinv_pkg.sv -----
// Shared types and constants for the modular inverse block.
// No dependencies.
`default_nettype none

package modinv_pkg;

  // Width of every numeric port field
  localparam int FIELD_BITS = 32;

  typedef logic [FIELD_BITS-1:0] field_t;

  // Sequencer states
  typedef enum logic [2:0] {
    MI_IDLE,
    MI_REDUCE,
    MI_LOOP,
    MI_DIVIDE,
    MI_FINISH
  } mi_state_t;

endpackage

`default_nettype wire

// ----- rtl/modular_inverse.sv -----
// Modular inverse by the extended Euclidean algorithm. Each item is a value
// and a modulus; the result is the inverse of the value modulo the modulus in
// 0..modulus-1, with no_inverse set (and inverse 0) when the modulus is 0 or
// shares a factor with the value. A modulus of 1 gives 0 with no flag. One
// item is in work at a time. The first reduction and each Euclid step run
// through the shared bit-serial divider, whose width W is VALUE_BITS capped
// at 32; a last loop check and the output write follow. The longest-running
// inputs are consecutive Fibonacci numbers; a modulus of 0 or 1 skips the
// divider. A finished result waits in an output register while the next
// item is accepted.
// Depends on modinv_pkg and modinv_div.
`default_nettype none

module modular_inverse
  import modinv_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_value,
  input  wire logic [31:0] in_modulus,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_inverse,
  output logic             out_no_inverse
);

  // Inputs wider than the port fields cannot occur
  localparam int W = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  mi_state_t    state_r, state_nxt;

  logic [W-1:0] m_r;
  logic [W-1:0] r_prev_r;
  logic [W-1:0] r_r;
  logic [W-1:0] t_prev_r;
  logic [W-1:0] t_r;
  logic         neg_r;
  logic [W-1:0] res_inv_r;
  logic         res_none_r;

  logic         out_valid_r;
  field_t       out_inverse_r;
  logic         out_none_r;

  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic [W-1:0] div_mult;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_prod;

  logic [W-1:0] in_a;
  logic [W-1:0] in_m;
  logic [W-1:0] mag;
  logic [W-1:0] fin_inv;
  logic         out_free;

  assign in_a     = in_value[W-1:0];
  assign in_m     = in_modulus[W-1:0];
  assign out_free = !out_valid_r || out_ready;

  // Final coefficient brought into 0..m-1
  always_comb begin
    mag     = (t_r == m_r) ? '0 : t_r;
    fin_inv = (neg_r && mag != '0) ? m_r - mag : mag;
  end

  modinv_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .mult     (div_mult),
    .done     (div_done),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  // Sequencer: next state and divider requests
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = r_prev_r;
    div_divisor  = r_r;
    div_mult     = t_r;
    unique case (state_r)
      MI_IDLE: begin
        in_ready     = 1'b1;
        div_dividend = in_a;
        div_divisor  = in_m;
        div_mult     = '0;
        if (in_valid) begin
          if (in_m == '0 || in_m == W'(1)) begin
            state_nxt = MI_FINISH;
          end else begin
            div_start = 1'b1;
            state_nxt = MI_REDUCE;
          end
        end
      end
      MI_REDUCE: begin
        if (div_done) state_nxt = MI_LOOP;
      end
      MI_LOOP: begin
        if (r_r > W'(1)) begin
          div_start = 1'b1;
          state_nxt = MI_DIVIDE;
        end else begin
          state_nxt = MI_FINISH;
        end
      end
      MI_DIVIDE: begin
        if (div_done) state_nxt = MI_LOOP;
      end
      MI_FINISH: begin
        if (out_free) state_nxt = MI_IDLE;
      end
      default: state_nxt = MI_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MI_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Euclid registers and pending result
  always_ff @(posedge clk) begin
    case (state_r)
      MI_IDLE: begin
        m_r        <= in_m;
        res_inv_r  <= '0;
        res_none_r <= (in_m == '0);
      end
      MI_REDUCE: begin
        if (div_done) begin
          r_prev_r <= m_r;
          r_r      <= div_rem;
          t_prev_r <= '0;
          t_r      <= W'(1);
          neg_r    <= 1'b0;
        end
      end
      MI_LOOP: begin
        if (r_r == W'(1)) begin
          res_inv_r  <= fin_inv;
          res_none_r <= 1'b0;
        end else if (r_r == '0) begin
          res_inv_r  <= '0;
          res_none_r <= 1'b1;
        end
      end
      MI_DIVIDE: begin
        if (div_done) begin
          r_prev_r <= r_r;
          r_r      <= div_rem;
          t_prev_r <= t_r;
          t_r      <= t_prev_r + div_prod;
          neg_r    <= !neg_r;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == MI_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MI_FINISH && out_free) begin
      out_inverse_r <= field_t'(res_inv_r);
      out_none_r    <= res_none_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inverse    = out_inverse_r;
  assign out_no_inverse = out_none_r;

endmodule

`default_nettype wire

// ----- rtl/modinv_div.sv -----
// Bit-serial restoring divider shared by all Euclid steps.
// Returns the remainder and quotient times a multiplicand; no dependencies.
`default_nettype none

module modinv_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  input  wire logic [W-1:0] mult,
  output logic              done,
  output logic [W-1:0]      rem,
  output logic [W-1:0]      prod
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dvs_r;
  logic [W-1:0]  mul_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  acc_r;

  logic [W:0]    rem_sh;
  logic          ge;
  logic [W:0]    rem_diff;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  acc_step;

  // One quotient bit per cycle while busy; the product q*mult is built MSB first
  always_comb begin
    rem_sh   = {rem_r, dvd_r[W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_diff = rem_sh - {1'b0, dvs_r};
    rem_step = ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
    acc_step = {acc_r[W-2:0], 1'b0} + (ge ? mul_r : '0);
  end

  // Control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CW'(W - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (start) begin
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      mul_r <= mult;
      rem_r <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= rem_step;
      acc_r <= acc_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// ----- rtl/modinv_checker.sv -----
// Port-level checks for modular_inverse, bound to the top level.
// Depends on modular_inverse_defines.svh.
`default_nettype none
`include "modular_inverse_defines.svh"

module modinv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_inverse,
  input wire logic        out_no_inverse
);

  // A waiting result holds still
  `MI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_inverse) && $stable(out_no_inverse), "result changed while stalled")

  // No inverse always reports zero
  `MI_ASSERT(a_none_zero, clk, rst_n, out_valid && out_no_inverse |-> out_inverse == 32'd0, "no_inverse with nonzero inverse")

  // One item in work at a time
  `MI_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready right after an accepted item")

  // Reset empties the output
  `MI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind modular_inverse modinv_checker u_modinv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inverse    (out_inverse),
  .out_no_inverse (out_no_inverse)
);

`default_nettype wire

// ----- tb/modular_inverse_test.sv -----
// Self-checking testbench for modular_inverse: directed operand table, then random
// operand pairs, every result checked against a hand-written one or an extended Euclid predictor.
// Depends on modinv_pkg and the modular_inverse RTL.
`timescale 1ns / 100ps

module modular_inverse_test
  import modinv_pkg::*;
();

  typedef struct packed {
    field_t inverse;
    logic   no_inverse;
  } inverse_result_t;

  // One row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    field_t          value;
    field_t          modulus;
    logic            fixed;
    inverse_result_t want;
  } operand_row_t;

  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_FROM    = 700;
  localparam int DIRECTED_ROWS = 24;

  localparam operand_row_t DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
    // modulus zero
    '{32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0, 1'b1}},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b1}},
    // modulus one
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{32'h0, 1'b0}},
    // value congruent to zero
    '{32'h0000_0000, 32'h0000_0007, 1'b1, '{32'h0, 1'b1}},
    '{32'h0000_000E, 32'h0000_0007, 1'b1, '{32'h0, 1'b1}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1}},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0, 1'b1}},
    // common factor
    '{32'h0000_0006, 32'h0000_0009, 1'b1, '{32'h0, 1'b1}},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h0, 1'b1}},
    // small and obvious inverses
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h1, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFE, 1'b0}},
    '{32'h0000_0002, 32'h0000_0003, 1'b1, '{32'h2, 1'b0}},
    '{32'h0000_0003, 32'h0000_0007, 1'b1, '{32'h5, 1'b0}},
    '{32'h0000_000A, 32'h0000_0007, 1'b1, '{32'h5, 1'b0}},
    '{32'h0000_0001, 32'h0000_0002, 1'b1, '{32'h1, 1'b0}},
    // wide operands, predictor-checked
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    // consecutive Fibonacci numbers (longest Euclid chain), then two other pairs
    '{32'd2971215073, 32'd1836311903, 1'b0, '0},
    '{32'd1836311903, 32'd2971215073, 1'b0, '0},
    '{32'd12345, 32'd65536, 1'b0, '0},
    '{32'd65537, 32'h8000_0001, 1'b0, '0}
  };

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  field_t in_value = '0;
  field_t in_modulus = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  field_t out_inverse;
  logic   out_no_inverse;

  // Hand-written result riding along with the item on the input port
  logic            hold_fixed = 1'b0;
  inverse_result_t hold_want = '0;
  logic            calm = 1'b0;

  inverse_result_t pending_inverses[$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int no_inverse_seen = 0;

  modular_inverse dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inverse    (out_inverse),
    .out_no_inverse (out_no_inverse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Extended Euclid on unsigned magnitudes with an alternating sign
  function automatic inverse_result_t compute_inverse(field_t value, field_t modulus);
    logic [63:0] rem_hi, rem_lo, coef_hi, coef_lo, quot, rem_next, coef_next, coef_mod;
    logic negative;
    inverse_result_t res;
    res = '0;
    if (modulus == '0) begin
      res.no_inverse = 1'b1;
      return res;
    end
    if (modulus == 32'd1)
      return res;
    rem_hi   = 64'(modulus);
    rem_lo   = 64'(value) % 64'(modulus);
    coef_hi  = 64'd0;
    coef_lo  = 64'd1;
    negative = 1'b0;
    while (rem_lo > 64'd1) begin
      quot      = rem_hi / rem_lo;
      rem_next  = rem_hi % rem_lo;
      rem_hi    = rem_lo;
      rem_lo    = rem_next;
      coef_next = coef_hi + quot * coef_lo;
      coef_hi   = coef_lo;
      coef_lo   = coef_next;
      negative  = ~negative;
    end
    if (rem_lo != 64'd1) begin
      res.no_inverse = 1'b1;
      return res;
    end
    coef_mod = coef_lo % 64'(modulus);
    if (negative && coef_mod != 64'd0)
      res.inverse = field_t'(64'(modulus) - coef_mod);
    else
      res.inverse = field_t'(coef_mod);
    return res;
  endfunction

  // Random operand pair drawn from a weighted mix of full-width, small and edge-case kinds
  function automatic void pick_operands(output field_t value, output field_t modulus);
    int     kind;
    field_t factor;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      value   = $urandom;
      modulus = $urandom;
    end else if (kind < 55) begin
      value   = $urandom;
      modulus = $urandom_range(2, 255);
    end else if (kind < 72) begin
      value   = $urandom_range(0, 65535);
      modulus = $urandom_range(2, 65535);
    end else if (kind < 84) begin
      factor  = $urandom_range(2, 1000);
      value   = factor * $urandom_range(1, 4000000);
      modulus = factor * $urandom_range(1, 4000000);
    end else if (kind < 90) begin
      value   = $urandom;
      modulus = $urandom_range(0, 1);
    end else if (kind < 95) begin
      modulus = $urandom;
      value   = modulus * $urandom_range(0, 3);
    end else begin
      // neighbors of the modulus: plus and minus one
      modulus = $urandom | 32'd1;
      value   = $urandom_range(0, 1) ? modulus - 32'd1 : modulus + 32'd1;
    end
  endfunction

  // Present one item at a falling edge and hold it until accepted
  task automatic send_item(field_t value, field_t modulus, logic fixed,
                           inverse_result_t want);
    in_value   <= value;
    in_modulus <= modulus;
    hold_fixed <= fixed;
    hold_want  <= want;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
    @(negedge clk);
  endtask

  // Sender gap: a random burst with valid low
  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // Receiver stalls in bursts, none in the closing stretch
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Record expectations on input handshakes, check on output handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_inverses.insert(pending_inverses.size(),
                                hold_fixed ? hold_want
                                           : compute_inverse(in_value, in_modulus));
      if (out_valid && out_ready) begin
        if (pending_inverses.size() == 0) begin
          $display("%0t: result with nothing expected: inverse %h no_inverse %b",
                   $time, out_inverse, out_no_inverse);
          error_count++;
        end else begin
          inverse_result_t want;
          want = pending_inverses.pop_front();
          results_checked++;
          if (out_no_inverse)
            no_inverse_seen++;
          if (out_inverse !== want.inverse) begin
            $display("%0t: inverse mismatch: expected %h actual %h",
                     $time, want.inverse, out_inverse);
            error_count++;
          end
          if (out_no_inverse !== want.no_inverse) begin
            $display("%0t: no_inverse mismatch: expected %b actual %b",
                     $time, want.no_inverse, out_no_inverse);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("Timeout with %0d results outstanding", pending_inverses.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    field_t value;
    field_t modulus;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_item(DIRECTED_TABLE[row].value, DIRECTED_TABLE[row].modulus,
                DIRECTED_TABLE[row].fixed, DIRECTED_TABLE[row].want);
      maybe_pause();
    end

    // Hold off until the block has drained
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);

    // Random operands
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FROM)
        calm <= 1'b1;
      pick_operands(value, modulus);
      send_item(value, modulus, 1'b0, '0);
      maybe_pause();
    end
    in_valid <= 1'b0;

    while (pending_inverses.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);

    $display("Sent %0d items (%0d directed); checked %0d results, %0d flagged no inverse",
             items_sent, DIRECTED_ROWS, results_checked, no_inverse_seen);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/modinv_pkg.sv
rtl/modinv_div.sv
rtl/modular_inverse.sv
rtl/modinv_checker.sv
tb/modular_inverse_test.sv
